// ----- rtl/core/adbtr_pkg.sv -----
`timescale 1ns / 1ps

package adbtr_pkg;

	// Reply frame geometry: a start cell, the data bits and a stop cell.
	localparam int REPLY_BITS  = 16;
	localparam int FRAME_CELLS = REPLY_BITS + 2;

	// Default depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Input item kinds.
	typedef enum logic [1:0] {
		FUNC_CMD   = 2'd0,
		FUNC_MOUSE = 2'd1,
		FUNC_KBD   = 2'd2,
		FUNC_MOD   = 2'd3
	} func_t;

	// Command and register codes in the low nibble of a command byte.
	localparam logic [3:0] OP_TALK0 = 4'hC;
	localparam logic [3:0] OP_TALK2 = 4'hE;
	localparam logic [3:0] OP_TALK3 = 4'hF;

	// Bits used to build replies.
	localparam logic [7:0] SKIP_KEY_UP  = 8'h80;
	localparam logic [7:0] SKIP_LOW     = 8'hFF;
	localparam logic [3:0] REG3_HI_NIB  = 4'h4;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOUSE_ADDR = 3'd0,
		CFG_KBD_ADDR   = 3'd1,
		CFG_ZERO_LOW   = 3'd2,
		CFG_ONE_LOW    = 3'd3,
		CFG_CELL       = 3'd4,
		CFG_INTERFRAME = 3'd5,
		CFG_SKIP_WIN   = 3'd6
	} cfg_idx_t;

	// Configuration register reset values.
	localparam logic [3:0]  RST_MOUSE_ADDR = 4'd3;
	localparam logic [3:0]  RST_KBD_ADDR   = 4'd2;
	localparam logic [7:0]  RST_ZERO_LOW   = 8'd65;
	localparam logic [7:0]  RST_ONE_LOW    = 8'd35;
	localparam logic [7:0]  RST_CELL       = 8'd100;
	localparam logic [7:0]  RST_INTERFRAME = 8'd180;
	localparam logic [15:0] RST_SKIP_WIN   = 16'd90;

	typedef struct packed {
		logic [3:0]  mouse_address;
		logic [3:0]  keyboard_address;
		logic [7:0]  zero_low_us;
		logic [7:0]  one_low_us;
		logic [7:0]  cell_us;
		logic [7:0]  interframe_us;
		logic [15:0] skip_window_ms;
	} cfg_t;

	// Flag values after an item, repeated on every result of that item.
	typedef struct packed {
		logic mouse_srq;
		logic keyboard_srq;
		logic mouse_waiting;
		logic keyboard_waiting;
	} flags_t;

	// Work handed from the front to the back for one item.
	typedef struct packed {
		logic                  has_frame;
		logic [REPLY_BITS-1:0] word;
		flags_t                flags;
	} job_t;

	// One result item.
	typedef struct packed {
		logic       cell_valid;
		logic       bit_value;
		logic [7:0] low_us;
		logic [7:0] high_us;
		logic [7:0] gap_us;
		logic       last_cell;
		flags_t     flags;
	} res_t;

endpackage

// ----- rtl/core/adb_device_talk_responder.sv -----
`timescale 1ns / 1ps
// An accepted item goes into the job queue and then into the back's output register.
// Throughput: the front takes one item per cycle while the job queue has room.
// The back sends one result per cycle while results are popped: 18 bit cells for a job
// with a reply frame, a status item otherwise. Sustained rate is set by the back serialiser.
// Reset is asynchronous, active low: device state and queue clear, registers take defaults.

module adb_device_talk_responder #(
	parameter int QUEUE_DEPTH = adbtr_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [adbtr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [adbtr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               push,
	output logic                               full,
	input  logic [1:0]                         func,
	input  logic [7:0]                         cmd_byte,
	input  logic [15:0]                        report_word,
	input  logic                               skip_mark,
	input  logic [7:0]                         prev_keycode,
	input  logic [31:0]                        now_ms,
	output logic                               empty,
	input  logic                               pop,
	output logic                               cell_valid,
	output logic                               bit_value,
	output logic [7:0]                         low_us,
	output logic [7:0]                         high_us,
	output logic [7:0]                         gap_us,
	output logic                               last_cell,
	output logic                               mouse_srq,
	output logic                               keyboard_srq,
	output logic                               mouse_waiting,
	output logic                               keyboard_waiting
);

	adbtr_pkg::cfg_t cfg_q;
	adbtr_pkg::job_t push_job, head_job;
	adbtr_pkg::res_t res;
	logic            job_push, job_pop, q_empty, res_valid;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mouse_address    <= adbtr_pkg::RST_MOUSE_ADDR;
			cfg_q.keyboard_address <= adbtr_pkg::RST_KBD_ADDR;
			cfg_q.zero_low_us      <= adbtr_pkg::RST_ZERO_LOW;
			cfg_q.one_low_us       <= adbtr_pkg::RST_ONE_LOW;
			cfg_q.cell_us          <= adbtr_pkg::RST_CELL;
			cfg_q.interframe_us    <= adbtr_pkg::RST_INTERFRAME;
			cfg_q.skip_window_ms   <= adbtr_pkg::RST_SKIP_WIN;
		end else if (cfg_we) begin
			unique case (adbtr_pkg::cfg_idx_t'(cfg_index))
				adbtr_pkg::CFG_MOUSE_ADDR: cfg_q.mouse_address    <= cfg_data[3:0];
				adbtr_pkg::CFG_KBD_ADDR:   cfg_q.keyboard_address <= cfg_data[3:0];
				adbtr_pkg::CFG_ZERO_LOW:   cfg_q.zero_low_us      <= cfg_data[7:0];
				adbtr_pkg::CFG_ONE_LOW:    cfg_q.one_low_us       <= cfg_data[7:0];
				adbtr_pkg::CFG_CELL:       cfg_q.cell_us          <= cfg_data[7:0];
				adbtr_pkg::CFG_INTERFRAME: cfg_q.interframe_us    <= cfg_data[7:0];
				adbtr_pkg::CFG_SKIP_WIN:   cfg_q.skip_window_ms   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front: accepts items, keeps device state, decides the reply.
	adbtr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.push         (push),
		.full         (full),
		.func         (func),
		.cmd_byte     (cmd_byte),
		.report_word  (report_word),
		.skip_mark    (skip_mark),
		.prev_keycode (prev_keycode),
		.now_ms       (now_ms),
		.job_push     (job_push),
		.job          (push_job)
	);

	// Queue of decided jobs between the front and the back.
	adbtr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (push_job),
		.full   (full),
		.rd_en  (job_pop),
		.rd_job (head_job),
		.empty  (q_empty)
	);

	// Back: serialises each job into bit cells or a status item.
	adbtr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job       (head_job),
		.job_empty (q_empty),
		.job_pop   (job_pop),
		.pop       (pop),
		.res_valid (res_valid),
		.res       (res)
	);

	assign empty            = !res_valid;
	assign cell_valid       = res.cell_valid;
	assign bit_value        = res.bit_value;
	assign low_us           = res.low_us;
	assign high_us          = res.high_us;
	assign gap_us           = res.gap_us;
	assign last_cell        = res.last_cell;
	assign mouse_srq        = res.flags.mouse_srq;
	assign keyboard_srq     = res.flags.keyboard_srq;
	assign mouse_waiting    = res.flags.mouse_waiting;
	assign keyboard_waiting = res.flags.keyboard_waiting;

`ifndef ASSERT_OFF
	// With nothing queued and nothing shown, no result can appear next cycle.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(q_empty && empty) |=> empty)
		else $error("result appeared without a queued job");

	// A status item is always the last result of its item.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !cell_valid) |-> last_cell)
		else $error("status item not marked last");

	// Only the start cell carries the interframe gap, and it is a one.
	a_gap_start: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && cell_valid && gap_us != 8'd0) |-> bit_value)
		else $error("gap on a cell that is not the start cell");

	// The mouse requests service only while its report is pending.
	a_mouse_srq: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && mouse_srq) |-> mouse_waiting)
		else $error("mouse service request without a pending report");
`endif

endmodule

// ----- rtl/core/adbtr_front.sv -----
`timescale 1ns / 1ps

module adbtr_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  adbtr_pkg::cfg_t                   cfg,
	input  logic                              push,
	input  logic                              full,
	input  logic [1:0]                        func,
	input  logic [7:0]                        cmd_byte,
	input  logic [adbtr_pkg::REPLY_BITS-1:0]  report_word,
	input  logic                              skip_mark,
	input  logic [7:0]                        prev_keycode,
	input  logic [31:0]                       now_ms,
	output logic                              job_push,
	output adbtr_pkg::job_t                   job
);

	logic                             mouse_pending_q, kbd_pending_q, kbd_skip_q;
	logic                             mouse_srq_q, kbd_srq_q;
	logic [adbtr_pkg::REPLY_BITS-1:0] mouse_word_q, kbd_word_q, modifier_word_q;
	logic [7:0]                       last_key_q;
	logic [31:0]                      skip_time_q;

	logic                             mouse_pending_d, kbd_pending_d, kbd_skip_d;
	logic                             mouse_srq_d, kbd_srq_d;
	logic [adbtr_pkg::REPLY_BITS-1:0] mouse_word_d, kbd_word_d, modifier_word_d;
	logic [7:0]                       last_key_d;
	logic [31:0]                      skip_time_d;

	logic [3:0]                       addr, op;
	logic [7:0]                       key_up;
	logic [31:0]                      since_skip;
	logic                             in_window;
	logic                             has_frame;
	logic [adbtr_pkg::REPLY_BITS-1:0] frame_word;

	assign job_push = push && !full;

	assign addr       = cmd_byte[7:4];
	assign op         = cmd_byte[3:0];
	assign key_up     = last_key_q | adbtr_pkg::SKIP_KEY_UP;
	assign since_skip = now_ms - skip_time_q;
	assign in_window  = since_skip < {16'd0, cfg.skip_window_ms};

	// Classify the item and work out the next device state and the frame to send.
	always_comb begin
		mouse_pending_d = mouse_pending_q;
		kbd_pending_d   = kbd_pending_q;
		kbd_skip_d      = kbd_skip_q;
		mouse_srq_d     = mouse_srq_q;
		kbd_srq_d       = kbd_srq_q;
		mouse_word_d    = mouse_word_q;
		kbd_word_d      = kbd_word_q;
		modifier_word_d = modifier_word_q;
		last_key_d      = last_key_q;
		skip_time_d     = skip_time_q;
		has_frame       = 1'b0;
		frame_word      = '0;
		unique case (adbtr_pkg::func_t'(func))
			adbtr_pkg::FUNC_MOUSE: begin
				mouse_word_d    = report_word;
				mouse_pending_d = 1'b1;
			end
			adbtr_pkg::FUNC_KBD: begin
				kbd_word_d    = report_word;
				kbd_skip_d    = skip_mark;
				last_key_d    = prev_keycode;
				kbd_pending_d = 1'b1;
			end
			adbtr_pkg::FUNC_MOD: begin
				modifier_word_d = report_word;
			end
			adbtr_pkg::FUNC_CMD: begin
				// The mouse answers only talk register 0.
				if (addr == cfg.mouse_address) begin
					if (op == adbtr_pkg::OP_TALK0 && mouse_pending_q) begin
						has_frame       = 1'b1;
						frame_word      = mouse_word_q;
						mouse_pending_d = 1'b0;
						mouse_srq_d     = 1'b0;
					end
				end else if (mouse_pending_q) begin
					mouse_srq_d = 1'b1;
				end
				// The keyboard stays silent when the mouse has already replied.
				if (addr == cfg.keyboard_address) begin
					if (!has_frame) begin
						if (op == adbtr_pkg::OP_TALK0 && kbd_pending_q) begin
							if (kbd_skip_q) begin
								// Skipped key: send a key-up of the previous key.
								kbd_skip_d  = 1'b0;
								last_key_d  = key_up;
								kbd_word_d  = {key_up, adbtr_pkg::SKIP_LOW};
								skip_time_d = now_ms;
								kbd_srq_d   = 1'b0;
								has_frame   = 1'b1;
								frame_word  = {key_up, adbtr_pkg::SKIP_LOW};
							end else if (!in_window) begin
								kbd_srq_d  = 1'b0;
								has_frame  = 1'b1;
								frame_word = kbd_word_q;
							end
							kbd_pending_d = 1'b0;
						end else if (op == adbtr_pkg::OP_TALK2) begin
							has_frame  = 1'b1;
							frame_word = modifier_word_q;
						end else if (op == adbtr_pkg::OP_TALK3) begin
							has_frame  = 1'b1;
							frame_word = {adbtr_pkg::REG3_HI_NIB, cfg.keyboard_address, 8'h00};
						end
					end
				end else if (kbd_pending_q) begin
					kbd_srq_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Hand the job to the queue with the flags as they stand after the item.
	always_comb begin
		job.has_frame              = has_frame;
		job.word                   = frame_word;
		job.flags.mouse_srq        = mouse_srq_d;
		job.flags.keyboard_srq     = kbd_srq_d;
		job.flags.mouse_waiting    = mouse_pending_d;
		job.flags.keyboard_waiting = kbd_pending_d;
	end

	// Device state registers, updated on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mouse_pending_q <= 1'b0;
			kbd_pending_q   <= 1'b0;
			kbd_skip_q      <= 1'b0;
			mouse_srq_q     <= 1'b0;
			kbd_srq_q       <= 1'b0;
			mouse_word_q    <= '0;
			kbd_word_q      <= '0;
			modifier_word_q <= '0;
			last_key_q      <= '0;
			skip_time_q     <= '0;
		end else if (job_push) begin
			mouse_pending_q <= mouse_pending_d;
			kbd_pending_q   <= kbd_pending_d;
			kbd_skip_q      <= kbd_skip_d;
			mouse_srq_q     <= mouse_srq_d;
			kbd_srq_q       <= kbd_srq_d;
			mouse_word_q    <= mouse_word_d;
			kbd_word_q      <= kbd_word_d;
			modifier_word_q <= modifier_word_d;
			last_key_q      <= last_key_d;
			skip_time_q     <= skip_time_d;
		end
	end

endmodule

// ----- rtl/core/adbtr_queue.sv -----
`timescale 1ns / 1ps

module adbtr_queue #(
	parameter int DEPTH = adbtr_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  adbtr_pkg::job_t wr_job,
	output logic            full,
	input  logic            rd_en,
	output adbtr_pkg::job_t rd_job,
	output logic            empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	adbtr_pkg::job_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = count_q == CNT_W'(DEPTH);
	assign empty  = count_q == '0;
	assign rd_job = mem_q[rd_ptr_q];

	// Job storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/adbtr_back.sv -----
`timescale 1ns / 1ps

module adbtr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  adbtr_pkg::cfg_t cfg,
	input  adbtr_pkg::job_t job,
	input  logic            job_empty,
	output logic            job_pop,
	input  logic            pop,
	output logic            res_valid,
	output adbtr_pkg::res_t res
);

	localparam int CNT_W = $clog2(adbtr_pkg::FRAME_CELLS);
	localparam int IDX_W = $clog2(adbtr_pkg::REPLY_BITS);

	logic [CNT_W-1:0] cnt_q;
	logic             res_valid_q;
	adbtr_pkg::res_t  res_q, res_d;
	logic             load, cell_last;
	logic [IDX_W-1:0] bit_pos;
	logic             bit_d;
	logic [7:0]       lo_d;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A new result goes to the output register when it is free or being taken.
	assign load      = (!res_valid_q || pop) && !job_empty;
	assign cell_last = !job.has_frame || cnt_q == CNT_W'(adbtr_pkg::FRAME_CELLS - 1);
	assign job_pop   = load && cell_last;

	// Start cell is one, data bits MSB first, stop cell is zero.
	assign bit_pos = IDX_W'(CNT_W'(adbtr_pkg::REPLY_BITS) - cnt_q);
	always_comb begin
		if (cnt_q == '0) begin
			bit_d = 1'b1;
		end else if (cnt_q == CNT_W'(adbtr_pkg::FRAME_CELLS - 1)) begin
			bit_d = 1'b0;
		end else begin
			bit_d = job.word[bit_pos];
		end
	end
	assign lo_d = bit_d ? cfg.one_low_us : cfg.zero_low_us;

	// Build the result: a bit cell, or a status item for a job without a frame.
	always_comb begin
		res_d.flags     = job.flags;
		res_d.last_cell = cell_last;
		if (job.has_frame) begin
			res_d.cell_valid = 1'b1;
			res_d.bit_value  = bit_d;
			res_d.low_us     = lo_d;
			res_d.high_us    = (cfg.cell_us > lo_d) ? cfg.cell_us - lo_d : 8'd0;
			res_d.gap_us     = (cnt_q == '0) ? cfg.interframe_us : 8'd0;
		end else begin
			res_d.cell_valid = 1'b0;
			res_d.bit_value  = 1'b0;
			res_d.low_us     = 8'd0;
			res_d.high_us    = 8'd0;
			res_d.gap_us     = 8'd0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	// Output valid and cell counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
				cnt_q       <= cell_last ? '0 : cnt_q + 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule
